[rtl/combperm_pkg.sv]
// Shared types and constants for the combinations and permutations unit.
// Used by combinations_permutations_unit; depends on nothing else.
`timescale 1ns / 1ps

package combperm_pkg;

  // Field widths of the request and the result.
  localparam int unsigned N_W     = 5;
  localparam int unsigned COUNT_W = 62;

  // Largest n or r that is answered.
  localparam logic [N_W-1:0] MAX_N = N_W'(20);

  // Every partial product i * C(m, i) of the combinations loop stays below 2^22.
  localparam int unsigned DIV_W     = 22;
  // The divider retires two quotient bits per cycle.
  localparam int unsigned DIV_STEPS = DIV_W / 2;
  localparam int unsigned DSTEP_W   = $clog2(DIV_STEPS + 1);

  // Operation select.
  localparam logic OP_COMB = 1'b0;
  localparam logic OP_PERM = 1'b1;

  typedef struct packed {
    logic           op;
    logic [N_W-1:0] n;
    logic [N_W-1:0] r;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               invalid;
  } res_t;

endpackage

[rtl/combinations_permutations_unit.sv]
// Top level of the combinations and permutations unit: sequencer, shared
// multiplier and a two-bit-per-cycle restoring divider. Depends on combperm_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Signals                 Transfer
// request   in         start, busy, req_i      start high and busy low at a clock edge
// result    out        done_o, res_o           one cycle with done_o high, always taken
//
// nPr multiplies r factors, one per multiply step, then raises the result strobe.
// nCr runs k = min(r, n - r) rounds, at most 10, each a multiply step followed by
// the divider loop, before it raises the strobe.
// A rejected request (r above n, or n or r above MAX_N) answers in the next cycle.
// Reset clears the sequencer and the strobe; busy stays high while an item runs.
// The result receiver cannot stall, so a result never waits.

module combinations_permutations_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  combperm_pkg::req_t  req_i,
  output logic                done_o,
  output combperm_pkg::res_t  res_o
);
  import combperm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  // One restoring division step: returns the quotient bit over the new remainder.
  function automatic logic [N_W:0] div_step(logic [N_W-1:0] rem, logic din,
                                            logic [N_W-1:0] dvs);
    logic [N_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, dvs}) begin
      div_step = {1'b1, N_W'(t - {1'b0, dvs})};
    end else begin
      div_step = {1'b0, t[N_W-1:0]};
    end
  endfunction

  logic [1:0]         state_q, state_d;
  logic               done_q, done_d;
  logic [N_W-1:0]     cnt_q, cnt_d;
  logic [DSTEP_W-1:0] dstep_q, dstep_d;
  logic               op_q, op_d;
  logic [COUNT_W-1:0] acc_q, acc_d;
  logic [N_W-1:0]     k_q, k_d;
  logic [N_W-1:0]     i_q, i_d;
  logic [DIV_W-1:0]   dvd_q, dvd_d;
  logic [N_W-1:0]     rem_q, rem_d;
  res_t               res_q, res_d;

  logic                   accept;
  logic                   bad;
  logic [N_W-1:0]         n_minus_r;
  logic [N_W-1:0]         r_small;
  logic [COUNT_W+N_W-1:0] prod_w;
  logic [N_W:0]           step_hi, step_lo;

  assign accept = start && !busy;

  // Request screening and the shorter side of the binomial.
  assign bad       = (req_i.n > MAX_N) || (req_i.r > MAX_N) || (req_i.r > req_i.n);
  assign n_minus_r = req_i.n - req_i.r;
  assign r_small   = (req_i.r > n_minus_r) ? n_minus_r : req_i.r;

  // The shared multiplier: running product times the current factor.
  assign prod_w = {{N_W{1'b0}}, acc_q} * {{COUNT_W{1'b0}}, k_q};

  // Two chained divide steps on the narrow remainder.
  assign step_hi = div_step(rem_q, dvd_q[DIV_W-1], i_q);
  assign step_lo = div_step(step_hi[N_W-1:0], dvd_q[DIV_W-2], i_q);

  // Sequencer and datapath next values.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dstep_d = dstep_q;
    op_d    = op_q;
    acc_d   = acc_q;
    k_d     = k_q;
    i_d     = i_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = req_i.op;
          acc_d = COUNT_W'(1);
          i_d   = N_W'(1);
          if (bad) begin
            res_d.count   = '0;
            res_d.invalid = 1'b1;
            done_d        = 1'b1;
          end else if (req_i.op == OP_PERM) begin
            cnt_d   = req_i.r;
            k_d     = n_minus_r + N_W'(1);
            state_d = ST_MUL;
          end else begin
            cnt_d   = r_small;
            k_d     = req_i.n - r_small + N_W'(1);
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (cnt_q == '0) begin
          res_d.count   = acc_q;
          res_d.invalid = 1'b0;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end else if (op_q == OP_PERM) begin
          acc_d = prod_w[COUNT_W-1:0];
          k_d   = k_q + N_W'(1);
          cnt_d = cnt_q - N_W'(1);
        end else begin
          // The partial product goes to the divider, which divides it by i.
          dvd_d   = prod_w[DIV_W-1:0];
          rem_d   = '0;
          dstep_d = DSTEP_W'(DIV_STEPS);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        dvd_d   = {dvd_q[DIV_W-3:0], step_hi[N_W], step_lo[N_W]};
        rem_d   = step_lo[N_W-1:0];
        dstep_d = dstep_q - DSTEP_W'(1);
        if (dstep_q == DSTEP_W'(1)) begin
          // The last step leaves the exact quotient in the dividend register.
          acc_d   = COUNT_W'({dvd_q[DIV_W-3:0], step_hi[N_W], step_lo[N_W]});
          k_d     = k_q + N_W'(1);
          i_d     = i_q + N_W'(1);
          cnt_d   = cnt_q - N_W'(1);
          state_d = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      dstep_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      dstep_q <= dstep_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    k_q   <= k_d;
    i_q   <= i_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  // A result only follows an accepted request or work in progress.
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result strobe without a request");

  // A rejected request always reports a zero count.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.invalid) |-> (res_o.count == '0))
    else $error("invalid result with nonzero count");

  // While dividing, the remainder stays below a nonzero divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((i_q != '0) && (rem_q < i_q)))
    else $error("divider remainder out of range");

  // The divider always hands back to the multiply step, never straight to idle.
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && (dstep_q == DSTEP_W'(1))) |=> (state_q == ST_MUL))
    else $error("divider exit out of sequence");
`endif

endmodule
